// File: sv/fwpp_pkg.sv
package fwpp_pkg;

   // default number of entries
   localparam int DEPTH_DEFAULT = 16;

   // field widths
   localparam int MODE_W      = 2;
   localparam int FLIGHT_W    = 16;
   localparam int POS_W       = 4;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_TAIL = 2'd0,
      MODE_POP_HEAD  = 2'd1,
      MODE_PUSH_HEAD = 2'd2,
      MODE_PROMOTE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

// File: sv/fifo_with_push_front_and_promote_core.sv
// Bounded deque of 16-bit flight numbers with move-to-front, held in a ring
// buffer RAM of DEPTH entries. Each request transaction carries one operation
// (push at tail, pop from head, push at head, or promote a position to the
// head) and produces exactly one response transaction with the taken value,
// the head after the operation, the entry count and a status code. The block
// handles one request at a time: a push, or a pop or promote on an empty
// deque, passes through the EXEC, HEAD and DONE states, a pop adds POP,
// and a promote adds TAKE and, unless it names the head, one SHIFT step per
// entry in front of it and then PUT; the shift loop moves one entry per
// cycle through the single ring-address adder and the one-read one-write
// RAM port pair. DONE waits for a free output register; the next request
// is accepted once the response is parked there, even if not yet taken.
module fifo_with_push_front_and_promote_core #(
   parameter int DEPTH = fwpp_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] mode, [17:2] flight_number, [21:18] position, [23:22] zero
   input  logic [fwpp_pkg::REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] taken_value, [31:16] head_value, [36:32] entry_count,
   // [38:37] status, [39] zero
   output logic [fwpp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > fwpp_pkg::POS_W) ? CW : fwpp_pkg::POS_W;

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_EXEC  = 8'b0000_0010,
      S_POP   = 8'b0000_0100,
      S_TAKE  = 8'b0000_1000,
      S_SHIFT = 8'b0001_0000,
      S_PUT   = 8'b0010_0000,
      S_HEAD  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type                           state_ff, state_in;
   fwpp_pkg::mode_type                  mode_ff, mode_in;
   logic [fwpp_pkg::FLIGHT_W-1:0]       value_ff, value_in;
   logic [fwpp_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [AW-1:0]                       head_ff, head_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [AW-1:0]                       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]                       rd_ptr_ff, rd_ptr_in;
   logic [fwpp_pkg::POS_W-1:0]          steps_ff, steps_in;
   logic [fwpp_pkg::FLIGHT_W-1:0]       taken_ff, taken_in;
   fwpp_pkg::status_type                status_ff, status_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [fwpp_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // shared ring address adder
   logic [AW-1:0] unit_base;
   logic [AW-1:0] unit_offset;
   logic [AW-1:0] unit_slot;

   // ram ports
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [fwpp_pkg::FLIGHT_W-1:0] ram_wr_data;
   logic [AW-1:0]                 ram_rd_addr;
   logic [fwpp_pkg::FLIGHT_W-1:0] ram_rd_data;

   // promote position clamped to the last entry
   logic [XW-1:0] pos_x;
   logic [XW-1:0] last_x;
   logic [XW-1:0] clamp_x;

   logic                          is_full;
   logic                          is_empty;
   logic                          out_free;
   logic [fwpp_pkg::FLIGHT_W-1:0] head_value;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign pos_x   = XW'(pos_ff);
   assign last_x  = XW'(count_ff) - XW'(1);
   assign clamp_x = (pos_x > last_x) ? last_x : pos_x;

   assign head_value = is_empty ? '0 : ram_rd_data;

   fwpp_ring_add #(
      .DEPTH (DEPTH)
   ) u_ring_add (
      .base   (unit_base),
      .offset (unit_offset),
      .slot   (unit_slot)
   );

   fwpp_ram #(
      .WIDTH (fwpp_pkg::FLIGHT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      steps_in     = steps_ff;
      taken_in     = taken_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      unit_base   = head_ff;
      unit_offset = '0;

      ram_wr_en   = 1'b0;
      ram_wr_addr = unit_slot;
      ram_wr_data = value_ff;
      ram_rd_addr = head_ff;

      // response leaves the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = fwpp_pkg::mode_type'(req_tdata[1:0]);
               value_in  = req_tdata[17:2];
               pos_in    = req_tdata[21:18];
               taken_in  = '0;
               status_in = fwpp_pkg::STATUS_OK;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_HEAD;
            case (mode_ff)
               fwpp_pkg::MODE_PUSH_TAIL: begin
                  // write one past the last entry
                  unit_offset = AW'(count_ff);
                  if (is_full) begin
                     status_in = fwpp_pkg::STATUS_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
               end
               fwpp_pkg::MODE_PUSH_HEAD: begin
                  // head steps back one slot with wrap
                  unit_offset = AW'(DEPTH - 1);
                  if (is_full) begin
                     status_in = fwpp_pkg::STATUS_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     head_in   = unit_slot;
                     count_in  = count_ff + CW'(1);
                  end
               end
               fwpp_pkg::MODE_POP_HEAD: begin
                  if (is_empty) begin
                     status_in = fwpp_pkg::STATUS_EMPTY;
                  end else begin
                     ram_rd_addr = head_ff;
                     state_in    = S_POP;
                  end
               end
               default: begin
                  // promote: fetch the chosen entry
                  unit_offset = AW'(clamp_x);
                  if (is_empty) begin
                     status_in = fwpp_pkg::STATUS_EMPTY;
                  end else begin
                     ram_rd_addr = unit_slot;
                     wr_ptr_in   = unit_slot;
                     steps_in    = fwpp_pkg::POS_W'(clamp_x);
                     state_in    = S_TAKE;
                  end
               end
            endcase
         end

         S_POP: begin
            taken_in    = ram_rd_data;
            unit_offset = AW'(1);
            head_in     = unit_slot;
            count_in    = count_ff - CW'(1);
            state_in    = S_HEAD;
         end

         S_TAKE: begin
            taken_in = ram_rd_data;
            if (steps_ff == '0) begin
               // promote of the head itself leaves the order as is
               state_in = S_HEAD;
            end else begin
               unit_base   = wr_ptr_ff;
               unit_offset = AW'(DEPTH - 1);
               ram_rd_addr = unit_slot;
               rd_ptr_in   = unit_slot;
               state_in    = S_SHIFT;
            end
         end

         S_SHIFT: begin
            // move the entry in front one slot back, prefetch the next one
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_ptr_ff;
            ram_wr_data = ram_rd_data;
            wr_ptr_in   = rd_ptr_ff;
            steps_in    = steps_ff - fwpp_pkg::POS_W'(1);
            if (steps_ff == fwpp_pkg::POS_W'(1)) begin
               state_in = S_PUT;
            end else begin
               unit_base   = rd_ptr_ff;
               unit_offset = AW'(DEPTH - 1);
               ram_rd_addr = unit_slot;
               rd_ptr_in   = unit_slot;
            end
         end

         S_PUT: begin
            // wr_ptr now points at the head slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_ptr_ff;
            ram_wr_data = taken_ff;
            state_in    = S_HEAD;
         end

         S_HEAD: begin
            ram_rd_addr = head_ff;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, status_ff,
                               fwpp_pkg::COUNT_OUT_W'(count_ff),
                               head_value, taken_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      wr_ptr_ff   <= wr_ptr_in;
      rd_ptr_ff   <= rd_ptr_in;
      steps_ff    <= steps_in;
      taken_ff    <= taken_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: sv/fwpp_ram.sv
module fwpp_ram #(
   parameter int WIDTH = fwpp_pkg::FLIGHT_W,
   parameter int DEPTH = fwpp_pkg::DEPTH_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fwpp_ring_add.sv
module fwpp_ring_add #(
   parameter int DEPTH = fwpp_pkg::DEPTH_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic [AW-1:0] base,
   input  logic [AW-1:0] offset,
   output logic [AW-1:0] slot
);

   // both operands stay below depth, so one compare and subtract wraps the sum
   logic [AW:0] sum;
   logic [AW:0] wrapped;

   assign sum     = {1'b0, base} + {1'b0, offset};
   assign wrapped = sum - (AW+1)'(DEPTH);
   assign slot    = (sum >= (AW+1)'(DEPTH)) ? wrapped[AW-1:0] : sum[AW-1:0];

endmodule

// File: tb/sv/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import fwpp_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int QUIET_LIMIT    = 2000;   // cycles with no transaction before giving up
   localparam int DRAIN_CYCLES   = 40;     // longer than the slowest promote
   localparam int ITEMS_PER_LEG  = 370;
   localparam int HOLD_OFF_LEN   = 400;

   // one expected response transaction
   typedef struct {
      logic [FLIGHT_W-1:0]    taken;
      logic [FLIGHT_W-1:0]    head;
      logic [COUNT_OUT_W-1:0] count;
      status_type             status;
   } deque_reply_t;

   // ------------------------------------------------------------------
   // deque tracker: mirrors the ring buffer and holds the responses that
   // are still owed by the block, oldest first
   // ------------------------------------------------------------------
   class flight_deque_tracker;
      logic [FLIGHT_W-1:0] slots [DEPTH];
      int unsigned         head_slot;
      int unsigned         held;
      deque_reply_t        awaited_replies [$];
      int unsigned         mismatches;
      int unsigned         mode_seen [4];
      int unsigned         empty_hits;
      int unsigned         full_hits;
      int unsigned         replies_checked;
      int unsigned         max_clamped;

      function new();
         head_slot = 0;
         held      = 0;
         mismatches = 0;
         empty_hits = 0;
         full_hits  = 0;
         replies_checked = 0;
         max_clamped = 0;
         foreach (mode_seen[i]) mode_seen[i] = 0;
      endfunction

      function int unsigned ring(int unsigned offset);
         return (head_slot + offset) % DEPTH;
      endfunction

      // apply one accepted request to the mirror and queue its response
      function void note_request(logic [REQ_DATA_W-1:0] data);
         mode_type            mode;
         logic [FLIGHT_W-1:0] flight;
         int unsigned         pos;
         deque_reply_t        reply;
         mode   = mode_type'(data[MODE_W-1:0]);
         flight = data[MODE_W +: FLIGHT_W];
         pos    = data[MODE_W+FLIGHT_W +: POS_W];
         reply.taken  = '0;
         reply.status = STATUS_OK;
         mode_seen[mode]++;
         case (mode)
            MODE_PUSH_TAIL: begin
               if (held >= DEPTH) begin
                  reply.status = STATUS_FULL;
               end else begin
                  slots[ring(held)] = flight;
                  held++;
               end
            end
            MODE_POP_HEAD: begin
               if (held == 0) begin
                  reply.status = STATUS_EMPTY;
               end else begin
                  reply.taken = slots[head_slot];
                  head_slot   = ring(1);
                  held--;
               end
            end
            MODE_PUSH_HEAD: begin
               if (held >= DEPTH) begin
                  reply.status = STATUS_FULL;
               end else begin
                  head_slot        = ring(DEPTH - 1);
                  slots[head_slot] = flight;
                  held++;
               end
            end
            default: begin
               if (held == 0) begin
                  reply.status = STATUS_EMPTY;
               end else begin
                  // clamp past the end to the last entry, then rotate it to the front
                  if (pos > held - 1) pos = held - 1;
                  if (pos > max_clamped) max_clamped = pos;
                  reply.taken = slots[ring(pos)];
                  for (int k = pos; k > 0; k--) slots[ring(k)] = slots[ring(k - 1)];
                  slots[head_slot] = reply.taken;
               end
            end
         endcase
         if (reply.status == STATUS_EMPTY) empty_hits++;
         if (reply.status == STATUS_FULL) full_hits++;
         reply.head  = (held > 0) ? slots[head_slot] : '0;
         reply.count = held[COUNT_OUT_W-1:0];
         awaited_replies.push_back(reply);
      endfunction

      function void compare_field(string name, logic [FLIGHT_W-1:0] want,
                                  logic [FLIGHT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      // compare one accepted response with the oldest expectation
      function void check_response(logic [RSP_DATA_W-1:0] data);
         deque_reply_t want;
         if (awaited_replies.size() == 0) begin
            $error("response transaction 0x%0h with no request outstanding", data);
            mismatches++;
            return;
         end
         want = awaited_replies.pop_front();
         replies_checked++;
         compare_field("taken_value", want.taken, data[15:0]);
         compare_field("head_value", want.head, data[31:16]);
         compare_field("entry_count", FLIGHT_W'(want.count), FLIGHT_W'(data[36:32]));
         compare_field("status", FLIGHT_W'(want.status), FLIGHT_W'(data[38:37]));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, reset and the block's ports
   // ------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [1:0] mode, [17:2] flight_number, [21:18] position, [23:22] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] taken_value, [31:16] head_value, [36:32] entry_count,
   // [38:37] status, [39] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fifo_with_push_front_and_promote_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   flight_deque_tracker book = new();

   // idling knobs, changed by the main sequence between legs
   int unsigned send_idle_pct   = 0;
   int unsigned stall_pct       = 0;
   int unsigned hold_off_cycles = 0;   // one-shot request for a long receiver hold

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   function automatic logic [REQ_DATA_W-1:0] pack_request(mode_type mode,
                                                          logic [FLIGHT_W-1:0] flight,
                                                          logic [POS_W-1:0] pos);
      return {2'b00, pos, flight, mode};
   endfunction

   // offer one request transaction and wait for it to be taken; tvalid only
   // drops when an idle gap is chosen, so back-to-back offers never toggle it
   task automatic send_request(logic [REQ_DATA_W-1:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(data);
   endtask

   // random request biased toward filling or draining, so the deque
   // wanders between empty and full
   function automatic logic [REQ_DATA_W-1:0] pick_request(int unsigned push_pct);
      mode_type            mode;
      logic [FLIGHT_W-1:0] flight;
      logic [POS_W-1:0]    pos;
      int unsigned         roll;
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) mode = mode_type'($urandom_range(3));
      else if (roll < push_pct) mode = $urandom_range(1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
      else mode = $urandom_range(1) ? MODE_POP_HEAD : MODE_PROMOTE;
      case ($urandom_range(15))
         0:       flight = '0;
         1:       flight = '1;
         default: flight = FLIGHT_W'($urandom);
      endcase
      // with more than one entry held, half the promotes land inside the held range, the rest anywhere
      if ($urandom_range(1) && book.held > 1) pos = POS_W'($urandom_range(book.held - 1));
      else pos = POS_W'($urandom_range(15));
      return pack_request(mode, flight, pos);
   endfunction

   // ------------------------------------------------------------------
   // response side: random stalls plus an occasional long hold-off
   // ------------------------------------------------------------------
   initial begin : response_sink
      int unsigned holding;
      holding = 0;
      forever begin
         if (hold_off_cycles != 0) begin
            holding         = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (holding != 0) begin
            rsp_tready <= 1'b0;
            holding--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) book.check_response(rsp_tdata);
      end
   end

   // ------------------------------------------------------------------
   // watchdog: ends the run when no transaction moves for too long
   // ------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("fifo_with_push_front_and_promote_core test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_sequence
      int unsigned leg_send [5];
      int unsigned leg_stall [5];
      int unsigned push_bias [3];
      int unsigned sent;
      leg_send  = '{0, 68, 0, 21, 0};
      leg_stall = '{0, 0, 68, 21, 0};
      push_bias = '{85, 50, 15};
      sent = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, value extremes, front pushes, promote of the
      // head and past the end, then fill up and hit the full case both ways
      send_request(pack_request(MODE_POP_HEAD, 16'h1234, 4'd0));
      send_request(pack_request(MODE_PROMOTE, 16'h0000, 4'd15));
      send_request(pack_request(MODE_PUSH_TAIL, 16'hFFFF, 4'd15));
      send_request(pack_request(MODE_PUSH_HEAD, 16'h0000, 4'd0));
      send_request(pack_request(MODE_PUSH_HEAD, 16'hA5A5, 4'd9));
      send_request(pack_request(MODE_PROMOTE, 16'hFFFF, 4'd0));
      send_request(pack_request(MODE_PROMOTE, 16'h0000, 4'd15));
      send_request(pack_request(MODE_POP_HEAD, 16'hFFFF, 4'd15));
      for (int i = 0; i < 14; i++) begin
         send_request(pack_request(MODE_PUSH_TAIL, FLIGHT_W'(16'h0100 + i), POS_W'(i)));
      end
      send_request(pack_request(MODE_PUSH_TAIL, 16'h5A5A, 4'd0));
      send_request(pack_request(MODE_PUSH_HEAD, 16'hC3C3, 4'd0));
      send_request(pack_request(MODE_PROMOTE, 16'h0000, 4'd15));

      // random legs: no idling, sender idle, receiver stalls, both, then
      // no idling with a long receiver hold-off so the block backs up
      for (int leg = 0; leg < 5; leg++) begin
         send_idle_pct = leg_send[leg];
         stall_pct     = leg_stall[leg];
         if (leg == 4) hold_off_cycles = HOLD_OFF_LEN;
         for (int i = 0; i < ITEMS_PER_LEG; i++) begin
            send_request(pick_request(push_bias[(sent / 60) % 3]));
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // drain whatever is still owed, then let any stray response show up
      while (book.awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d push tail, %0d pop, %0d push head, %0d promote",
               book.mode_seen[0] + book.mode_seen[1] + book.mode_seen[2] + book.mode_seen[3],
               book.mode_seen[0], book.mode_seen[1], book.mode_seen[2], book.mode_seen[3]);
      $display("%0d responses checked, %0d empty and %0d full cases, deepest promote %0d",
               book.replies_checked, book.empty_hits, book.full_hits, book.max_clamped);
      if (book.mismatches == 0 && book.awaited_replies.size() == 0) begin
         $display("fifo_with_push_front_and_promote_core test passed");
      end else begin
         $display("fifo_with_push_front_and_promote_core test failed");
      end
      $finish;
   end

endmodule
